@@ sv/smeu_pkg.sv @@
// Shared types and codes for the stack machine execute unit.
// No dependencies; imported by the top level, the multiplier and the checker.
package smeu_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int WORD_W          = 64;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [3:0] {
        KIND_NOP    = 4'd0,
        KIND_PUSH   = 4'd1,
        KIND_ADD    = 4'd2,
        KIND_DUP    = 4'd3,
        KIND_DROP   = 4'd4,
        KIND_MUL    = 4'd5,
        KIND_EQ     = 4'd6,
        KIND_READ   = 4'd7,
        KIND_WRITE  = 4'd8,
        KIND_JUMP   = 4'd9,
        KIND_BRANCH = 4'd10,
        KIND_HALT   = 4'd11
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_OVER   = 3'd2,
        ST_RANGE  = 3'd3,
        ST_HALTED = 3'd4
    } status_t;

endpackage

@@ sv/smeu_mul.sv @@
// Iterative 64-bit multiplier keeping the low product: one 32x32 partial product per cycle.
// Depends on smeu_pkg.
module smeu_mul
    import smeu_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t op_a,
    input  word_t op_b,
    output logic  done,
    output word_t product
);

    localparam int HALF_W = WORD_W / 2;

    word_t             a_reg;
    word_t             b_reg;
    word_t             prod_reg;
    word_t             acc_reg;
    logic [1:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    word_t             mult_out;
    word_t             acc_next;

    // step 0: lo*lo, step 1: lo*hi, step 2: hi*lo; the high*high term falls off the top
    always_comb
    begin
        a_half   = (step_reg == 2'd2) ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half   = (step_reg == 2'd1) ? b_reg[WORD_W-1:HALF_W] : b_reg[HALF_W-1:0];
        mult_out = a_half * b_half;
        if (step_reg == 2'd1)
        begin
            acc_next = prod_reg;
        end
        else
        begin
            acc_next = acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        else if (busy_reg)
        begin
            prod_reg <= mult_out;
            if (step_reg != 2'd0)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ sv/stack_machine_execute_unit_top.sv @@
// Channel  Direction  Handshake            Payload
// cmd      in         cmd_valid/cmd_stall  kind, immediate
// res      out        res_valid/res_stall  top_value, depth, branch_taken, status, halted
//
// One transaction at a time: accept issues the stack memory read and execute writes back;
// a mul that executes hands off to smeu_mul and waits for its four steps.
// The stack lives in a single-port-write, one-read synchronous memory; the top entry is
// also held in a register. The next item is taken only after write-back, so no forwarding.
// Reset clears depth and the halt flag; the memory is not cleared (only values of written
// entries are used). A stalled result holds the unit in execute until it is taken.
// Depends on smeu_pkg and smeu_mul.
module stack_machine_execute_unit_top
    import smeu_pkg::*;
#(
    parameter  int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int SP_W        = $clog2(STACK_DEPTH + 1),
    localparam int ADDR_W      = $clog2(STACK_DEPTH)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  logic [3:0]      kind,
    input  logic [63:0]     immediate,
    output logic            res_valid,
    input  logic            res_stall,
    output logic [63:0]     top_value,
    output logic [SP_W-1:0] depth,
    output logic            branch_taken,
    output logic [2:0]      status,
    output logic            halted
);

    localparam logic [SP_W-1:0] DEPTH_MAX = SP_W'(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MUL
    } state_t;

    state_t          state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    word_t           top_reg, top_next;
    logic            halt_reg, halt_next;
    logic            res_valid_reg, res_valid_next;
    word_t           res_top_reg, res_top_next;
    logic [SP_W-1:0] res_depth_reg, res_depth_next;
    logic            res_taken_reg, res_taken_next;
    status_t         res_status_reg, res_status_next;
    logic            res_halted_reg, res_halted_next;

    logic [3:0]      kind_reg;
    word_t           imm_reg;

    word_t             stack_mem [STACK_DEPTH];
    word_t             rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    word_t             mem_wdata;
    logic [SP_W-1:0]   rd_ptr;

    logic            cmd_accept;
    logic            out_free;
    logic [SP_W-1:0] sp_m1;
    logic [SP_W-1:0] sp_m2;
    logic [SP_W-1:0] wr_ptr;
    logic            has1;
    logic            has2;
    logic            full;
    logic            read_bad;
    logic            write_bad;
    word_t           sum;
    word_t           eq_word;
    logic            mul_start;
    logic            mul_done;
    word_t           mul_product;

    assign cmd_accept = cmd_valid && (state_reg == S_IDLE);
    assign cmd_stall  = (state_reg != S_IDLE);
    assign out_free   = !res_valid_reg || !res_stall;

    // read address comes straight from the incoming transaction
    assign rd_ptr = (kind == KIND_READ) ? (sp_reg - immediate[SP_W-1:0])
                                        : (sp_reg - SP_W'(2));

    assign sp_m1     = sp_reg - SP_W'(1);
    assign sp_m2     = sp_reg - SP_W'(2);
    assign wr_ptr    = sp_m1 - imm_reg[SP_W-1:0];
    assign has1      = (sp_reg != '0);
    assign has2      = (sp_reg > SP_W'(1));
    assign full      = (sp_reg == DEPTH_MAX);
    assign read_bad  = (imm_reg == '0) || (imm_reg > WORD_W'(sp_reg));
    assign write_bad = (imm_reg == '0) || (imm_reg > WORD_W'(sp_m1));
    assign sum       = top_reg + rd_data_reg;
    assign eq_word   = (top_reg == rd_data_reg) ? WORD_W'(1) : '0;

    smeu_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (top_reg),
        .op_b    (rd_data_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd_accept)
        begin
            rd_data_reg <= stack_mem[rd_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            kind_reg <= kind;
            imm_reg  <= immediate;
        end
    end

    always_comb
    begin
        logic    commit;
        status_t st;
        logic    tk;

        commit          = 1'b0;
        st              = ST_OK;
        tk              = 1'b0;
        state_next      = state_reg;
        sp_next         = sp_reg;
        top_next        = top_reg;
        halt_next       = halt_reg;
        mem_we          = 1'b0;
        mem_waddr       = sp_reg[ADDR_W-1:0];
        mem_wdata       = top_reg;
        mul_start       = 1'b0;
        res_valid_next  = res_valid_reg && res_stall;
        res_top_next    = res_top_reg;
        res_depth_next  = res_depth_reg;
        res_taken_next  = res_taken_reg;
        res_status_next = res_status_reg;
        res_halted_next = res_halted_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                    if (halt_reg)
                    begin
                        st = ST_HALTED;
                    end
                    else
                    begin
                        case (kind_reg)
                            KIND_PUSH:
                            begin
                                if (full)
                                begin
                                    st = ST_OVER;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    mem_wdata = imm_reg;
                                    sp_next   = sp_reg + SP_W'(1);
                                    top_next  = imm_reg;
                                end
                            end
                            KIND_ADD, KIND_EQ:
                            begin
                                if (!has2)
                                begin
                                    st = ST_UNDER;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = sp_m2[ADDR_W-1:0];
                                    mem_wdata = (kind_reg == KIND_ADD) ? sum : eq_word;
                                    top_next  = mem_wdata;
                                    sp_next   = sp_m1;
                                end
                            end
                            KIND_MUL:
                            begin
                                if (!has2)
                                begin
                                    st = ST_UNDER;
                                end
                                else
                                begin
                                    // hand off to the multiplier, commit later
                                    commit     = 1'b0;
                                    mul_start  = 1'b1;
                                    state_next = S_MUL;
                                end
                            end
                            KIND_DUP:
                            begin
                                if (!has1)
                                begin
                                    st = ST_UNDER;
                                end
                                else if (full)
                                begin
                                    st = ST_OVER;
                                end
                                else
                                begin
                                    mem_we  = 1'b1;
                                    sp_next = sp_reg + SP_W'(1);
                                end
                            end
                            KIND_DROP:
                            begin
                                if (!has1)
                                begin
                                    st = ST_UNDER;
                                end
                                else
                                begin
                                    sp_next  = sp_m1;
                                    top_next = rd_data_reg;
                                end
                            end
                            KIND_READ:
                            begin
                                if (read_bad)
                                begin
                                    st = ST_RANGE;
                                end
                                else if (full)
                                begin
                                    st = ST_OVER;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    mem_wdata = rd_data_reg;
                                    sp_next   = sp_reg + SP_W'(1);
                                    top_next  = rd_data_reg;
                                end
                            end
                            KIND_WRITE:
                            begin
                                if (!has1)
                                begin
                                    st = ST_UNDER;
                                end
                                else if (write_bad)
                                begin
                                    st = ST_RANGE;
                                end
                                else
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = wr_ptr[ADDR_W-1:0];
                                    sp_next   = sp_m1;
                                    // offset one overwrites the new top with the old top
                                    top_next  = (imm_reg == WORD_W'(1)) ? top_reg : rd_data_reg;
                                end
                            end
                            KIND_JUMP:
                            begin
                                tk = 1'b1;
                            end
                            KIND_BRANCH:
                            begin
                                if (!has1)
                                begin
                                    st = ST_UNDER;
                                end
                                else
                                begin
                                    tk       = (top_reg != '0);
                                    sp_next  = sp_m1;
                                    top_next = rd_data_reg;
                                end
                            end
                            KIND_HALT:
                            begin
                                halt_next = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_MUL:
            begin
                if (mul_done && out_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                    mem_we     = 1'b1;
                    mem_waddr  = sp_m2[ADDR_W-1:0];
                    mem_wdata  = mul_product;
                    sp_next    = sp_m1;
                    top_next   = mul_product;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit)
        begin
            res_valid_next  = 1'b1;
            res_top_next    = (sp_next != '0) ? top_next : '0;
            res_depth_next  = sp_next;
            res_taken_next  = tk;
            res_status_next = st;
            res_halted_next = halt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sp_reg         <= '0;
            top_reg        <= '0;
            halt_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_top_reg    <= '0;
            res_depth_reg  <= '0;
            res_taken_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            res_halted_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            top_reg        <= top_next;
            halt_reg       <= halt_next;
            res_valid_reg  <= res_valid_next;
            res_top_reg    <= res_top_next;
            res_depth_reg  <= res_depth_next;
            res_taken_reg  <= res_taken_next;
            res_status_reg <= res_status_next;
            res_halted_reg <= res_halted_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign top_value    = res_top_reg;
    assign depth        = res_depth_reg;
    assign branch_taken = res_taken_reg;
    assign status       = res_status_reg;
    assign halted       = res_halted_reg;

endmodule

@@ sv/smeu_checker.sv @@
// Port-level assertions for the stack machine execute unit, bound to the top level.
// Depends on smeu_pkg and stack_machine_execute_unit_top.
module smeu_checker
    import smeu_pkg::*;
#(
    parameter  int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int SP_W        = $clog2(STACK_DEPTH + 1)
)
(
    input logic            clk,
    input logic            rst_n,
    input logic            res_valid,
    input logic            res_stall,
    input logic [63:0]     top_value,
    input logic [SP_W-1:0] depth,
    input logic            branch_taken,
    input logic [2:0]      status,
    input logic            halted
);

    // hold a stalled result transaction
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(top_value) && $stable(depth))
        else $error("stalled result changed");

    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> depth <= SP_W'(STACK_DEPTH))
        else $error("depth beyond stack size");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && depth == '0 |-> top_value == '0)
        else $error("empty stack shows nonzero top");

    a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && branch_taken |-> status == ST_OK && !halted)
        else $error("branch taken on a faulted or ignored item");

    a_halted_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_HALTED |-> halted)
        else $error("ignored item without halted flag");

endmodule

bind stack_machine_execute_unit_top smeu_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_smeu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .top_value    (top_value),
    .depth        (depth),
    .branch_taken (branch_taken),
    .status       (status),
    .halted       (halted)
);

@@ tb/stack_machine_execute_unit_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for stack_machine_execute_unit_top: directed and random stack
// operations, every result predicted by a shadow stack and compared field by field.
// Depends on smeu_pkg and the execute unit RTL.
module stack_machine_execute_unit_top_tb;
    import smeu_pkg::*;

    localparam int         DEPTH_MAX     = STACK_DEPTH_DEF;
    localparam int         RANDOM_ITEMS  = 2000;
    localparam int         DRAIN_CYCLES  = 40;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam logic [3:0] KIND_SPARE_LO = 4'd12;
    localparam logic [3:0] KIND_SPARE_HI = 4'd15;
    localparam int         MODE_GROW     = 0;
    localparam int         MODE_SHRINK   = 1;
    localparam int         MODE_MIX      = 2;

    typedef struct {
        word_t      top;
        logic [8:0] depth;
        logic       taken;
        status_t    status;
        logic       halted;
    } outcome_t;

    // Shadow of the operand stack; queues the outcome of every accepted transaction.
    class stack_shadow;
        word_t       cells [DEPTH_MAX];
        int unsigned sp           = 0;
        bit          halt_seen    = 1'b0;
        outcome_t    pending [$];
        int unsigned error_count  = 0;
        int unsigned result_count = 0;

        function void note_command(logic [3:0] op, word_t imm);
            outcome_t    o;
            word_t       a;
            word_t       b;
            word_t       r;
            int unsigned rest;
            o.taken  = 1'b0;
            o.status = ST_OK;
            if (halt_seen)
            begin
                o.status = ST_HALTED;
            end
            else
            begin
                case (op)
                    KIND_PUSH:
                    begin
                        if (sp >= DEPTH_MAX)
                            o.status = ST_OVER;
                        else
                        begin
                            cells[sp] = imm;
                            sp++;
                        end
                    end
                    KIND_ADD, KIND_MUL, KIND_EQ:
                    begin
                        if (sp < 2)
                            o.status = ST_UNDER;
                        else
                        begin
                            a = cells[sp-1];
                            b = cells[sp-2];
                            if (op == KIND_ADD)
                                r = a + b;
                            else if (op == KIND_MUL)
                                r = a * b;
                            else
                                r = (a == b) ? word_t'(1) : word_t'(0);
                            cells[sp-2] = r;
                            sp--;
                        end
                    end
                    KIND_DUP:
                    begin
                        if (sp < 1)
                            o.status = ST_UNDER;
                        else if (sp >= DEPTH_MAX)
                            o.status = ST_OVER;
                        else
                        begin
                            cells[sp] = cells[sp-1];
                            sp++;
                        end
                    end
                    KIND_DROP:
                    begin
                        if (sp < 1)
                            o.status = ST_UNDER;
                        else
                            sp--;
                    end
                    KIND_READ:
                    begin
                        // range is checked ahead of overflow
                        if (imm == 0 || imm > sp)
                            o.status = ST_RANGE;
                        else if (sp >= DEPTH_MAX)
                            o.status = ST_OVER;
                        else
                        begin
                            cells[sp] = cells[sp - imm[31:0]];
                            sp++;
                        end
                    end
                    KIND_WRITE:
                    begin
                        if (sp < 1)
                            o.status = ST_UNDER;
                        else
                        begin
                            // offset counts from the top left after the pop
                            rest = sp - 1;
                            if (imm == 0 || imm > rest)
                                o.status = ST_RANGE;
                            else
                            begin
                                cells[rest - imm[31:0]] = cells[rest];
                                sp = rest;
                            end
                        end
                    end
                    KIND_JUMP:
                        o.taken = 1'b1;
                    KIND_BRANCH:
                    begin
                        if (sp < 1)
                            o.status = ST_UNDER;
                        else
                        begin
                            o.taken = (cells[sp-1] != 0);
                            sp--;
                        end
                    end
                    KIND_HALT:
                        halt_seen = 1'b1;
                    default:
                    begin
                    end
                endcase
            end
            o.top    = (sp > 0) ? cells[sp-1] : '0;
            o.depth  = 9'(sp);
            o.halted = halt_seen;
            pending.push_back(o);
        endfunction

        task flag_mismatch(string msg);
            $display("mismatch: %s", msg);
            error_count++;
        endtask

        task check_result(word_t top, logic [8:0] dep, logic taken, logic [2:0] st, logic hlt);
            outcome_t o;
            result_count++;
            if (pending.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d arrived with nothing pending", result_count));
                return;
            end
            o = pending.pop_front();
            if (top !== o.top)
                flag_mismatch($sformatf("result %0d top_value %h, want %h",
                                        result_count, top, o.top));
            if (dep !== o.depth)
                flag_mismatch($sformatf("result %0d depth %0d, want %0d",
                                        result_count, dep, o.depth));
            if (taken !== o.taken)
                flag_mismatch($sformatf("result %0d branch_taken %b, want %b",
                                        result_count, taken, o.taken));
            if (st !== o.status)
                flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                        result_count, st, o.status));
            if (hlt !== o.halted)
                flag_mismatch($sformatf("result %0d halted %b, want %b",
                                        result_count, hlt, o.halted));
        endtask
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cmd_valid    = 1'b0;
    logic       cmd_stall;
    logic [3:0] kind         = '0;
    word_t      immediate    = '0;
    logic       res_valid;
    logic       res_stall    = 1'b0;
    word_t      top_value;
    logic [8:0] depth;
    logic       branch_taken;
    logic [2:0] status;
    logic       halted;

    stack_shadow shadow      = new();
    int unsigned burst_left  = 0;
    int unsigned hold_left   = 0;
    int unsigned cycle_count = 0;

    stack_machine_execute_unit_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .kind         (kind),
        .immediate    (immediate),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .top_value    (top_value),
        .depth        (depth),
        .branch_taken (branch_taken),
        .status       (status),
        .halted       (halted)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Offer one transaction and hold it until accepted; bursts may be separated by idle gaps.
    task automatic send_command(input logic [3:0] op, input word_t imm);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                cmd_valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_valid <= 1'b1;
        kind      <= op;
        immediate <= imm;
        do
            @(posedge clk);
        while (cmd_stall);
        shadow.note_command(op, imm);
        burst_left--;
    endtask

    function automatic word_t pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return word_t'($urandom_range(0, 3));
            3:       return word_t'(1) << $urandom_range(0, 63);
            4:       return ~(word_t'(1) << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // span is the largest offset that is in range
    function automatic word_t pick_offset(int unsigned span);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return word_t'(span + 1);
            2:       return {$urandom, $urandom};
            default: return (span == 0) ? word_t'(1) : word_t'($urandom_range(1, span));
        endcase
    endfunction

    function automatic logic [3:0] pick_kind(int mode);
        int unsigned r;
        logic [3:0]  k;
        r = $urandom_range(0, 99);
        do
            k = 4'($urandom_range(0, 15));
        while (k == KIND_HALT);
        if (mode == MODE_GROW)
        begin
            if (r < 45)
                k = KIND_PUSH;
            else if (r < 60)
                k = KIND_DUP;
            else if (r < 75)
                k = KIND_READ;
        end
        else if (mode == MODE_SHRINK)
        begin
            if (r < 20)
                k = KIND_DROP;
            else if (r < 32)
                k = KIND_ADD;
            else if (r < 40)
                k = KIND_MUL;
            else if (r < 50)
                k = KIND_EQ;
            else if (r < 65)
                k = KIND_BRANCH;
            else if (r < 80)
                k = KIND_WRITE;
        end
        return k;
    endfunction

    task automatic run_phase(int mode, int unsigned count);
        logic [3:0] op;
        word_t      imm;
        repeat (count)
        begin
            op = pick_kind(mode);
            case (op)
                KIND_PUSH:  imm = pick_value();
                KIND_READ:  imm = pick_offset(shadow.sp);
                KIND_WRITE: imm = pick_offset((shadow.sp == 0) ? 0 : shadow.sp - 1);
                default:    imm = {$urandom, $urandom};
            endcase
            send_command(op, imm);
        end
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty stack: every pop and every read is refused
        send_command(KIND_ADD, '0);
        send_command(KIND_DROP, '0);
        send_command(KIND_DUP, '0);
        send_command(KIND_WRITE, word_t'(1));
        send_command(KIND_BRANCH, '0);
        send_command(KIND_READ, word_t'(1));
        // wrapping arithmetic at the extremes
        send_command(KIND_PUSH, '0);
        send_command(KIND_PUSH, '1);
        send_command(KIND_PUSH, '1);
        send_command(KIND_MUL, '0);
        send_command(KIND_PUSH, '1);
        send_command(KIND_ADD, '0);
        send_command(KIND_EQ, '0);
        send_command(KIND_DUP, '0);
        send_command(KIND_PUSH, word_t'(5));
        send_command(KIND_EQ, '0);
        // offsets at and past the edges
        send_command(KIND_READ, '0);
        send_command(KIND_READ, word_t'(3));
        send_command(KIND_READ, word_t'(2));
        send_command(KIND_PUSH, word_t'(7));
        send_command(KIND_WRITE, '0);
        send_command(KIND_WRITE, word_t'(4));
        send_command(KIND_WRITE, word_t'(3));
        send_command(KIND_READ, '1);
        send_command(KIND_JUMP, '1);
        send_command(KIND_BRANCH, '0);
        send_command(KIND_SPARE_LO, '1);
        send_command(KIND_SPARE_HI, '0);
        send_command(KIND_NOP, '1);

        // fill past full, drain past empty, then mixed phases
        run_phase(MODE_GROW, 450);
        run_phase(MODE_SHRINK, 450);
        sent = 900;
        while (sent < RANDOM_ITEMS)
        begin
            len = $urandom_range(20, 200);
            run_phase($urandom_range(MODE_GROW, MODE_MIX), len);
            sent += len;
        end

        // after halt everything, halt included, is refused
        send_command(KIND_HALT, {$urandom, $urandom});
        run_phase(MODE_MIX, 10);
        send_command(KIND_HALT, '0);
        send_command(KIND_PUSH, '1);
        cmd_valid <= 1'b0;

        while (shadow.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shadow.error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Take results; stall in free runs, held stalls and per-cycle toggling.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                shadow.check_result(top_value, depth, branch_taken, status, halted);
            if (hold_left != 0)
            begin
                hold_left--;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        res_stall <= 1'b0;
                        hold_left = $urandom_range(0, 15);
                    end
                    4, 5, 6:
                    begin
                        res_stall <= 1'b1;
                        hold_left = $urandom_range(0, 6);
                    end
                    default:
                        res_stall <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
sv/smeu_pkg.sv
sv/smeu_mul.sv
sv/stack_machine_execute_unit_top.sv
sv/smeu_checker.sv
tb/stack_machine_execute_unit_top_tb.sv
